[hdl/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define LRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lrt_pkg.sv]
`timescale 1ns / 1ps
package lrt_pkg;

	localparam int ADDR_W          = 32;
	localparam int LEN_W           = 6;
	localparam int IFACE_W         = 8;
	localparam int DEF_TABLE_DEPTH = 64;
	localparam int QUEUE_DEPTH     = 2;

	// Request action codes
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NOP    = 2'd3
	} action_e;

	// Classified operation kinds
	typedef enum logic [3:0] {
		OP_INSERT = 4'b0001,
		OP_DELETE = 4'b0010,
		OP_LOOKUP = 4'b0100,
		OP_NOP    = 4'b1000
	} op_kind_e;

	typedef struct packed {
		logic [1:0]         action;
		logic [ADDR_W-1:0]  address;
		logic [LEN_W-1:0]   prefix_len;
		logic [ADDR_W-1:0]  next_hop_in;
		logic [IFACE_W-1:0] interface_in;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [ADDR_W-1:0]  next_hop_out;
		logic [IFACE_W-1:0] interface_out;
		logic               status;
	} rsp_t;

	typedef struct packed {
		op_kind_e           kind;
		logic [ADDR_W-1:0]  address;
		logic [LEN_W-1:0]   prefix_len;
		logic [ADDR_W-1:0]  next_hop;
		logic [IFACE_W-1:0] iface;
	} op_t;

	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  prefix;
		logic [LEN_W-1:0]   length;
		logic [ADDR_W-1:0]  next_hop;
		logic [IFACE_W-1:0] iface;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Network mask with the top len bits set; lengths above the address width saturate.
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else if (len >= LEN_W'(ADDR_W)) begin
			m = '1;
		end else begin
			m = ~({ADDR_W{1'b1}} >> len);
		end
		return m;
	endfunction

endpackage

[hdl/lrt_ram.sv]
`timescale 1ns / 1ps
module lrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hdl/lrt_queue.sv]
`timescale 1ns / 1ps
module lrt_queue
	import lrt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  op_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output op_t  out_data
);

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	op_t            slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           push;
	logic           pop;

	assign in_stall  = (count_q == QCW'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	function automatic logic [QAW-1:0] ptr_next(input logic [QAW-1:0] p);
		return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + QAW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

[hdl/lrt_front.sv]
`timescale 1ns / 1ps
module lrt_front
	import lrt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic hold,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic op_valid,
	input  logic op_stall,
	output op_t  op
);

	logic     vld_s1;
	op_t      op_s1;
	op_kind_e kind;
	logic     take;

	always_comb begin
		case (action_e'(req.action))
			ACT_INSERT: kind = OP_INSERT;
			ACT_DELETE: kind = OP_DELETE;
			ACT_LOOKUP: kind = OP_LOOKUP;
			default:    kind = OP_NOP;
		endcase
	end

	assign req_stall = hold || (vld_s1 && op_stall);
	assign take      = req_valid && !req_stall;
	assign op_valid  = vld_s1;
	assign op        = op_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1.kind       <= kind;
			op_s1.address    <= req.address;
			op_s1.prefix_len <= req.prefix_len;
			op_s1.next_hop   <= req.next_hop_in;
			op_s1.iface      <= req.interface_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (vld_s1 && !op_stall) begin
			vld_s1 <= 1'b0;
		end
	end

endmodule

[hdl/lrt_back.sv]
`timescale 1ns / 1ps
module lrt_back
	import lrt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_stall,
	input  op_t  op,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp,
	output logic clearing
);

	localparam int IW = $clog2(TABLE_DEPTH);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_e;

	state_e             state_q;
	logic [IW-1:0]      cnt_q;
	logic               issue_q;
	op_t                op_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic               rd_last_s1;
	logic               key_hit_q;
	logic [IW-1:0]      key_idx_q;
	logic               free_hit_q;
	logic [IW-1:0]      free_idx_q;
	logic               best_hit_q;
	logic [LEN_W-1:0]   best_len_q;
	logic [ADDR_W-1:0]  best_nh_q;
	logic [IFACE_W-1:0] best_if_q;
	rsp_t               out_q;
	logic               out_vld_q;

	logic               ram_wr_en;
	logic [IW-1:0]      ram_wr_addr;
	entry_t             ram_wr_data;
	logic               ram_rd_en;
	logic [ENTRY_W-1:0] ram_rd_data;
	entry_t             e;
	logic               key_match;
	logic               pfx_match;
	logic               finish_go;
	logic               cnt_last;
	rsp_t               rsp_next;

	lrt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(cnt_q),
		.rd_data(ram_rd_data)
	);

	assign e         = entry_t'(ram_rd_data);
	assign cnt_last  = (cnt_q == IW'(TABLE_DEPTH - 1));
	assign op_stall  = (state_q != ST_IDLE);
	assign clearing  = (state_q == ST_CLEAR);
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;
	assign ram_rd_en = (state_q == ST_SCAN) && issue_q;
	assign finish_go = (state_q == ST_FINISH) && (!out_vld_q || !rsp_stall);

	assign key_match = e.valid && (e.prefix == op_q.address) && (e.length == op_q.prefix_len);
	assign pfx_match = e.valid && (e.length <= LEN_W'(ADDR_W))
		&& ((op_q.address & prefix_mask(e.length)) == e.prefix);

	// Memory write and result: clearing sweep, or the single commit of insert/delete; lookups fill the result
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = cnt_q;
		ram_wr_data = '0;
		rsp_next    = '0;
		if (state_q == ST_CLEAR) begin
			ram_wr_en = 1'b1;
		end else if (state_q == ST_FINISH) begin
			case (op_q.kind)
				OP_INSERT: begin
					ram_wr_data.valid    = 1'b1;
					ram_wr_data.prefix   = op_q.address;
					ram_wr_data.length   = op_q.prefix_len;
					ram_wr_data.next_hop = op_q.next_hop;
					ram_wr_data.iface    = op_q.iface;
					if (key_hit_q) begin
						ram_wr_en   = finish_go;
						ram_wr_addr = key_idx_q;
					end else if (free_hit_q) begin
						ram_wr_en   = finish_go;
						ram_wr_addr = free_idx_q;
					end else begin
						rsp_next.status = 1'b1;
					end
				end
				OP_DELETE: begin
					ram_wr_en   = finish_go && key_hit_q;
					ram_wr_addr = key_idx_q;
				end
				OP_LOOKUP: begin
					rsp_next.found         = best_hit_q;
					rsp_next.next_hop_out  = best_nh_q;
					rsp_next.interface_out = best_if_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && op_valid) begin
			op_q <= op;
		end
		if (finish_go) begin
			out_q <= rsp_next;
		end
		rd_idx_s1  <= cnt_q;
		rd_last_s1 <= cnt_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			issue_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			key_hit_q  <= 1'b0;
			key_idx_q  <= '0;
			free_hit_q <= 1'b0;
			free_idx_q <= '0;
			best_hit_q <= 1'b0;
			best_len_q <= '0;
			best_nh_q  <= '0;
			best_if_q  <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_rd_en;

			if (finish_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_last ? '0 : cnt_q + IW'(1);
					if (cnt_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (op_valid) begin
						cnt_q      <= '0;
						issue_q    <= (op.kind != OP_NOP);
						key_hit_q  <= 1'b0;
						free_hit_q <= 1'b0;
						best_hit_q <= 1'b0;
						best_len_q <= '0;
						best_nh_q  <= '0;
						best_if_q  <= '0;
						state_q    <= (op.kind == OP_NOP) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (cnt_last) begin
							issue_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + IW'(1);
						end
					end
					if (rd_vld_s1) begin
						if (key_match && !key_hit_q) begin
							key_hit_q <= 1'b1;
							key_idx_q <= rd_idx_s1;
						end
						if (!e.valid && !free_hit_q) begin
							free_hit_q <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
						// Keep the first entry of the longest matching length
						if (pfx_match && (!best_hit_q || (e.length > best_len_q))) begin
							best_hit_q <= 1'b1;
							best_len_q <= e.length;
							best_nh_q  <= e.next_hop;
							best_if_q  <= e.iface;
						end
						if (rd_last_s1) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/lpm_route_table.sv]
`timescale 1ns / 1ps
// Flow: a request passes the front register and the queue to the scan engine, which reads
// the entry memory one entry per cycle, then commits and registers the result; a request with
// an unused action code skips the scan. The engine serves one request at a time while the queue
// holds further ones. Reset: arst_n clears control state, then a clearing pass writes every
// entry invalid, during which req_stall stays high.
`include "assert_macros.svh"
module lpm_route_table
	import lrt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Front side: register and classify the request
	logic fr_valid;
	logic fr_stall;
	op_t  fr_op;

	// Queue output toward the scan engine
	logic q_valid;
	logic q_stall;
	op_t  q_op;

	logic clearing;

	// Hold off new requests while the clearing pass runs
	lrt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (clearing),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.op_valid (fr_valid),
		.op_stall (fr_stall),
		.op       (fr_op)
	);

	// Decouple the front from the scan so requests keep arriving during a scan
	lrt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_stall (fr_stall),
		.in_data  (fr_op),
		.out_valid(q_valid),
		.out_stall(q_stall),
		.out_data (q_op)
	);

	// Back side: scan the table, commit insert/delete, drive the result register
	lrt_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_valid),
		.op_stall (q_stall),
		.op       (q_op),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.clearing (clearing)
	);

	`LRT_ASSERT_NOW(a_clear_blocks_req, clk, arst_n, clearing, req_stall, "request taken during clear")
	`LRT_ASSERT_NOW(a_clear_no_rsp, clk, arst_n, clearing, !rsp_valid, "result during clear pass")
	`LRT_ASSERT_NOW(a_found_not_dropped, clk, arst_n, rsp_valid && rsp.found, !rsp.status, "found and dropped")
	`LRT_ASSERT_NOW(a_miss_zero, clk, arst_n, rsp_valid && !rsp.found, (rsp.next_hop_out == '0) && (rsp.interface_out == '0), "miss carries data")

endmodule

[verif/lpm_route_table_check.sv]
`timescale 1ns / 1ps
module lpm_route_table_check
	import lrt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   expected_count
);

	logic               route_valid    [TABLE_DEPTH];
	logic [ADDR_W-1:0]  route_prefix   [TABLE_DEPTH];
	logic [LEN_W-1:0]   route_length   [TABLE_DEPTH];
	logic [ADDR_W-1:0]  route_next_hop [TABLE_DEPTH];
	logic [IFACE_W-1:0] route_iface    [TABLE_DEPTH];

	rsp_t rsp_expected[$];
	rsp_t rsp_want;

	// Apply one request to the shadow table and return the response it should produce.
	function automatic rsp_t route_update(input req_t r);
		rsp_t             res;
		int               slot;
		int               best;
		logic [LEN_W-1:0] best_len;
		res      = '0;
		slot     = -1;
		best     = -1;
		best_len = '0;
		case (r.action)
		ACT_INSERT: begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (slot < 0 && route_valid[i] && route_prefix[i] == r.address &&
					route_length[i] == r.prefix_len)
					slot = i;
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (slot < 0 && !route_valid[i])
					slot = i;
			if (slot < 0) begin
				res.status = 1'b1;
			end else begin
				route_valid[slot]    = 1'b1;
				route_prefix[slot]   = r.address;
				route_length[slot]   = r.prefix_len;
				route_next_hop[slot] = r.next_hop_in;
				route_iface[slot]    = r.interface_in;
			end
		end
		ACT_DELETE: begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (slot < 0 && route_valid[i] && route_prefix[i] == r.address &&
					route_length[i] == r.prefix_len)
					slot = i;
			if (slot >= 0)
				route_valid[slot] = 1'b0;
		end
		ACT_LOOKUP: begin
			// Lengths past the address width never match.
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (route_valid[i] && route_length[i] <= LEN_W'(ADDR_W) &&
					(r.address & ~({ADDR_W{1'b1}} >> route_length[i])) == route_prefix[i] &&
					(best < 0 || route_length[i] > best_len)) begin
					best     = i;
					best_len = route_length[i];
				end
			end
			if (best >= 0) begin
				res.found         = 1'b1;
				res.next_hop_out  = route_next_hop[best];
				res.interface_out = route_iface[best];
			end
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				route_valid[i] = 1'b0;
			rsp_expected.delete();
			fail_count     = 0;
			expected_count = 0;
		end else begin
			// Retire the response first: it always belongs to an older request.
			if (rsp_valid && !rsp_stall) begin
				if (rsp_expected.size() == 0) begin
					$display("%0t: response with none expected, expected none actual %0h",
						$time, rsp);
					fail_count++;
				end else begin
					rsp_want = rsp_expected.pop_front();
					report_field("found", 32'(rsp_want.found), 32'(rsp.found));
					report_field("next_hop_out", rsp_want.next_hop_out, rsp.next_hop_out);
					report_field("interface_out", 32'(rsp_want.interface_out),
						32'(rsp.interface_out));
					report_field("status", 32'(rsp_want.status), 32'(rsp.status));
				end
			end
			if (req_valid && !req_stall)
				rsp_expected.push_back(route_update(req));
			expected_count = rsp_expected.size();
		end
	end

endmodule

[verif/lpm_route_table_test.sv]
`timescale 1ns / 1ps
module lpm_route_table_test;
	import lrt_pkg::*;

	// Run bounds: the cycle limit ends a hung run; the rest size the drain, the hold-off and each phase.
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = DEF_TABLE_DEPTH + 16;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 200;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	int fail_count;
	int expected_count;
	int cycles        = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	// Keys believed to be in the table; lets deletes and lookups hit real routes.
	logic [ADDR_W-1:0] key_addr[$];
	logic [LEN_W-1:0]  key_len[$];
	// Few top octets so that random routes nest and longest match has a choice.
	logic [7:0]        base_octet[4] = '{8'd10, 8'd172, 8'd192, 8'd255};

	lpm_route_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	lpm_route_table_check check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.fail_count     (fail_count),
		.expected_count (expected_count)
	);

	always #5 clk = ~clk;

	// Bound the run: a hung handshake ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Response side: random stalls, or a long hold-off when the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			rsp_stall   <= 1'b1;
			hold_left   <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	function automatic req_t route_req(input action_e act, input logic [ADDR_W-1:0] addr,
		input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] nh,
		input logic [IFACE_W-1:0] ifc);
		req_t r;
		r.action       = act;
		r.address      = addr;
		r.prefix_len   = len;
		r.next_hop_in  = nh;
		r.interface_in = ifc;
		return r;
	endfunction

	// Offer one request and hold it until accepted. Valid stays high into the next
	// request unless an idle cycle is drawn.
	task automatic send_request(input req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Random requests: mostly well-formed operations on known keys, with some noise.
	task automatic run_phase(input int items, input int insert_pct, input int delete_pct);
		req_t              r;
		int                pick;
		int                roll;
		int                len_roll;
		logic [ADDR_W-1:0] mask;
		repeat (items) begin
			r.next_hop_in  = $urandom;
			r.interface_in = IFACE_W'($urandom);
			r.prefix_len   = LEN_W'($urandom);
			r.address      = $urandom;
			roll = $urandom_range(0, 99);
			if (roll < insert_pct) begin
				r.action = ACT_INSERT;
				if (key_addr.size() > 0 && $urandom_range(0, 4) == 0) begin
					// Replace an existing key with new data.
					pick         = $urandom_range(0, key_addr.size() - 1);
					r.address    = key_addr[pick];
					r.prefix_len = key_len[pick];
				end else begin
					len_roll = $urandom_range(0, 19);
					if (len_roll == 0)
						r.prefix_len = LEN_W'($urandom_range(33, 63));
					else if (len_roll < 3)
						r.prefix_len = LEN_W'($urandom_range(0, 7));
					else
						r.prefix_len = LEN_W'($urandom_range(8, 32));
					r.address = {base_octet[$urandom_range(0, 3)], 24'($urandom)};
					// Keep host bits now and then; such a route never matches.
					if ($urandom_range(0, 9) != 0)
						r.address = r.address & ~({ADDR_W{1'b1}} >> r.prefix_len);
					key_addr.push_back(r.address);
					key_len.push_back(r.prefix_len);
				end
			end else if (roll < insert_pct + delete_pct) begin
				r.action = ACT_DELETE;
				if (key_addr.size() > 0 && $urandom_range(0, 4) != 0) begin
					pick         = $urandom_range(0, key_addr.size() - 1);
					r.address    = key_addr[pick];
					r.prefix_len = key_len[pick];
					key_addr.delete(pick);
					key_len.delete(pick);
				end
			end else if (roll < 97) begin
				r.action = ACT_LOOKUP;
				if (key_addr.size() > 0 && $urandom_range(0, 3) != 0) begin
					// Query inside a known route, random bits below its length.
					pick      = $urandom_range(0, key_addr.size() - 1);
					mask      = ~({ADDR_W{1'b1}} >> key_len[pick]);
					r.address = (key_addr[pick] & mask) | (r.address & ~mask);
				end
			end else begin
				r.action = ACT_NOP;
			end
			send_request(r);
		end
	endtask

	initial begin
		send_idle_pct = 21;
		recv_idle_pct = 67;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, nested routes, odd keys, replace, delete, no-op.
		send_request(route_req(ACT_LOOKUP, 32'h0A00_0001, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_INSERT, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF, 8'hFF));
		send_request(route_req(ACT_INSERT, 32'h0A00_0000, 6'd8, 32'h0000_0001, 8'h01));
		send_request(route_req(ACT_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_0002, 8'h02));
		send_request(route_req(ACT_INSERT, 32'h0A01_0203, 6'd32, 32'h0000_0003, 8'h03));
		send_request(route_req(ACT_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_LOOKUP, 32'h0A01_0909, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_LOOKUP, 32'h0AC8_0001, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_LOOKUP, 32'hC0A8_0101, 6'd0, 32'h0, 8'h0));
		// Route stored with host bits set: present, but never matched.
		send_request(route_req(ACT_INSERT, 32'h0A02_0005, 6'd16, 32'h0000_0004, 8'h04));
		send_request(route_req(ACT_LOOKUP, 32'h0A02_0005, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_DELETE, 32'h0A02_0005, 6'd16, 32'h0, 8'h0));
		// Lengths over the address width: stored, never matched.
		send_request(route_req(ACT_INSERT, 32'h0A01_0203, 6'd33, 32'h0000_0005, 8'h05));
		send_request(route_req(ACT_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h0000_0006, 8'h06));
		send_request(route_req(ACT_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_DELETE, 32'h0A01_0203, 6'd33, 32'h0, 8'h0));
		// Replace an existing key.
		send_request(route_req(ACT_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_0022, 8'h22));
		send_request(route_req(ACT_LOOKUP, 32'h0A01_0505, 6'd0, 32'h0, 8'h0));
		// Delete of a missing key, then the unused action code with all bits set.
		send_request(route_req(ACT_DELETE, 32'h0B00_0000, 6'd8, 32'h0, 8'h0));
		send_request(route_req(ACT_NOP, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 8'hFF));
		// Drop the default route: a foreign address now misses.
		send_request(route_req(ACT_DELETE, 32'h0000_0000, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_LOOKUP, 32'hC0A8_0101, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h0000_0000, 8'h00));
		send_request(route_req(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h0));
		send_request(route_req(ACT_DELETE, 32'h0A01_0203, 6'd32, 32'h0, 8'h0));
		send_request(route_req(ACT_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0, 8'h0));

		// Insert-heavy: fill the table so that new keys get dropped.
		run_phase(PHASE_ITEMS, 70, 15);

		// Swap the idle rates; start with a long response hold-off to back up the block.
		send_idle_pct = 67;
		recv_idle_pct = 21;
		hold_requests <= hold_requests + 1;
		run_phase(PHASE_ITEMS, 35, 40);

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(PHASE_ITEMS, 45, 20);

		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/lrt_pkg.sv
hdl/lrt_ram.sv
hdl/lrt_queue.sv
hdl/lrt_front.sv
hdl/lrt_back.sv
hdl/lpm_route_table.sv
verif/lpm_route_table_check.sv
verif/lpm_route_table_test.sv
